>>> src/assert_macros.svh
// Assertion macros for the escaper RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define UJSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define UJSE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define UJSE_ASSERT(lbl, clk, rstn, prop, msg)
`define UJSE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> src/ujse_pkg.sv
// Shared types, constants and helper functions of the UTF-8 JSON string escaper.
// No dependencies; every other source file but assert_macros.svh uses it.
`timescale 1ns / 1ps

package ujse_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned MaxTok   = 6;
  localparam int unsigned TokIdxW  = $clog2(MaxTok);
  localparam int unsigned SubW     = 3;
  localparam int unsigned MaxChr   = 26;
  localparam int unsigned ChrW     = $clog2(MaxChr + 1);
  localparam int unsigned OutLimit = 21;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [QCntW-1:0] QFull    = QCntW'(QDepth);
  localparam logic [ChrW-1:0]  LimitPos = ChrW'(OutLimit - 1);

  localparam logic [CharW-1:0] ChQuote  = 7'h22;
  localparam logic [CharW-1:0] ChBslash = 7'h5C;
  localparam logic [CharW-1:0] ChLowU   = 7'h75;
  localparam logic [CharW-1:0] ChLowN   = 7'h6E;
  localparam logic [CharW-1:0] ChLowR   = 7'h72;
  localparam logic [CharW-1:0] ChLowT   = 7'h74;
  localparam logic [CharW-1:0] ChLowB   = 7'h62;
  localparam logic [CharW-1:0] ChLowF   = 7'h66;

  typedef enum logic [1:0] {
    TK_CHAR,
    TK_ESC,
    TK_UNIT,
    TK_CLOSE
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] val;
  } tok_t;

  typedef struct packed {
    tok_t [MaxTok-1:0]  tok;
    logic [TokIdxW-1:0] n_tok;
    logic [ChrW-1:0]    n_chr;
  } job_t;

  typedef struct packed {
    logic head_valid;
    logic next_valid;
    logic next_empty;
    logic full;
  } q_stat_t;

  function automatic logic [SubW-1:0] tok_len(tok_kind_e k);
    logic [SubW-1:0] n;
    case (k)
      TK_ESC:  n = SubW'(2);
      TK_UNIT: n = SubW'(6);
      default: n = SubW'(1);
    endcase
    return n;
  endfunction

  function automatic logic [CharW-1:0] hex_char(logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'd0, nib};
    end else begin
      c = 7'h57 + {3'd0, nib};
    end
    return c;
  endfunction

endpackage

>>> src/ujse_intf.sv
// Handshake interfaces for the byte input and the character output channels.
// Depends on ujse_pkg for field widths.
`timescale 1ns / 1ps

interface ujse_in_if;
  logic                       valid;
  logic                       ready;
  logic [ujse_pkg::ByteW-1:0] in_byte;
  logic                       has_byte;
  logic                       end_of_string;

  modport source (output valid, output in_byte, output has_byte, output end_of_string,
                  input ready);
  modport sink (input valid, input in_byte, input has_byte, input end_of_string,
                output ready);
endinterface

interface ujse_out_if;
  logic                       valid;
  logic                       ready;
  logic [ujse_pkg::CharW-1:0] out_byte;
  logic                       run_end;
  logic                       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_end, input string_end,
                output ready);
endinterface

>>> src/utf8_json_string_escaper_top.sv
// Top level of the UTF-8 to ASCII-only JSON string escaper.
// Depends on ujse_pkg, ujse_intf, ujse_front, ujse_queue, ujse_back and assert_macros.svh.
//
//   channel  dir  payload                                  transfer when
//   in_i     in   in_byte[7:0], has_byte, end_of_string    valid && ready
//   out_o    out  out_byte[6:0], run_end, string_end       valid && ready
//
// The front end takes one item per cycle while the four-entry job queue has room.
// The back end sends one character per cycle while the output is not stalled. An item
// yields 1 character for plain ASCII, 6 per \uXXXX unit, up to 25; one that yields none
// is popped without output. Output stalls hold the output register and fill the queue.
// Characters beyond 21 for one item are held until the next item is queued.
// Reset is asynchronous and empties the queue and the decode state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_json_string_escaper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ujse_in_if.sink     in_i,
  ujse_out_if.source  out_o
);

  logic              push;
  logic              pop;
  ujse_pkg::job_t    job;
  ujse_pkg::job_t    head;
  ujse_pkg::q_stat_t stat;
  logic              close_bad;

  ujse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (stat.full),
    .push_o   (push),
    .job_o    (job)
  );

  ujse_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  ujse_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  assign close_bad = out_o.valid && out_o.string_end && (out_o.out_byte != ujse_pkg::ChQuote);

  `UJSE_ASSERT(a_pop_needs_head, clk_i, rst_ni, pop |-> stat.head_valid, "pop from empty queue")
  `UJSE_ASSERT(a_full_from_push, clk_i, rst_ni, $rose(stat.full) |-> $past(push), "full w/o push")
  `UJSE_ASSERT_NEVER(a_close_is_quote, clk_i, rst_ni, close_bad, "string end off a quote")
  `UJSE_ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, push && stat.full && !pop, "push when full")

endmodule

>>> src/ujse_front.sv
// Front end: accepts input items, tracks the UTF-8 decode state and turns each item into a job.
// Depends on ujse_pkg and ujse_in_if.
`timescale 1ns / 1ps

module ujse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ujse_in_if.sink         in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ujse_pkg::job_t  job_o
);

  logic        inside_q, inside_d;
  logic [7:0]  lead_q, lead_d;
  logic [1:0]  need_q, need_d;
  logic [1:0]  held_q, held_d;
  logic [7:0]  hc_q [2];
  logic [7:0]  hc_d [2];
  logic [20:0] part_q, part_d;
  logic [20:0] part_ext;
  logic [20:0] adj;
  logic [7:0]  b;
  logic        fresh;
  logic        take;
  ujse_pkg::job_t job;

  function automatic ujse_pkg::job_t add_tok(ujse_pkg::job_t j, ujse_pkg::tok_kind_e k,
                                             logic [15:0] v);
    ujse_pkg::job_t r;
    r = j;
    r.tok[j.n_tok].kind = k;
    r.tok[j.n_tok].val  = v;
    r.n_tok = j.n_tok + 1'b1;
    r.n_chr = j.n_chr + ujse_pkg::ChrW'(ujse_pkg::tok_len(k));
    return r;
  endfunction

  function automatic ujse_pkg::job_t add_flush(ujse_pkg::job_t j, logic [7:0] lead,
                                               logic [1:0] nheld, logic [7:0] h0,
                                               logic [7:0] h1);
    ujse_pkg::job_t r;
    r = add_tok(j, ujse_pkg::TK_UNIT, {8'd0, lead});
    if (nheld != 2'd0) begin
      r = add_tok(r, ujse_pkg::TK_UNIT, {8'd0, h0});
    end
    if (nheld > 2'd1) begin
      r = add_tok(r, ujse_pkg::TK_UNIT, {8'd0, h1});
    end
    return r;
  endfunction

  function automatic ujse_pkg::job_t add_fresh(ujse_pkg::job_t j, logic [7:0] c);
    ujse_pkg::job_t r;
    r = j;
    if (c inside {8'h22, 8'h5C}) begin
      r = add_tok(j, ujse_pkg::TK_ESC, {8'd0, c});
    end else if (c == 8'h0A) begin
      r = add_tok(j, ujse_pkg::TK_ESC, {9'd0, ujse_pkg::ChLowN});
    end else if (c == 8'h0D) begin
      r = add_tok(j, ujse_pkg::TK_ESC, {9'd0, ujse_pkg::ChLowR});
    end else if (c == 8'h09) begin
      r = add_tok(j, ujse_pkg::TK_ESC, {9'd0, ujse_pkg::ChLowT});
    end else if (c == 8'h08) begin
      r = add_tok(j, ujse_pkg::TK_ESC, {9'd0, ujse_pkg::ChLowB});
    end else if (c == 8'h0C) begin
      r = add_tok(j, ujse_pkg::TK_ESC, {9'd0, ujse_pkg::ChLowF});
    end else if (c < 8'h20) begin
      r = add_tok(j, ujse_pkg::TK_UNIT, {8'd0, c});
    end else if (c < 8'h80) begin
      r = add_tok(j, ujse_pkg::TK_CHAR, {8'd0, c});
    end else if (c inside {[8'hC0:8'hF7]}) begin
      r = j;
    end else begin
      r = add_tok(j, ujse_pkg::TK_UNIT, {8'd0, c});
    end
    return r;
  endfunction

  assign in_i.ready = !q_full_i;
  assign take       = in_i.valid && in_i.ready;
  assign push_o     = take;
  assign job_o      = job;

  always_comb begin
    job      = '0;
    inside_d = inside_q;
    lead_d   = lead_q;
    need_d   = need_q;
    held_d   = held_q;
    hc_d     = hc_q;
    part_d   = part_q;
    fresh    = 1'b0;
    b        = in_i.in_byte;
    part_ext = {part_q[14:0], b[5:0]};
    adj      = part_ext - 21'h10000;

    if ((in_i.has_byte || in_i.end_of_string) && !inside_q) begin
      job      = add_tok(job, ujse_pkg::TK_CHAR, {9'd0, ujse_pkg::ChQuote});
      inside_d = 1'b1;
    end

    if (in_i.has_byte) begin
      if (need_q == 2'd0) begin
        fresh = 1'b1;
      end else if (b[7:6] == 2'b10) begin
        if (({1'b0, held_q} + 3'd1) >= {1'b0, need_q}) begin
          if (part_ext[20:16] != 5'd0) begin
            job = add_tok(job, ujse_pkg::TK_UNIT, 16'hD800 + {5'd0, adj[20:10]});
            job = add_tok(job, ujse_pkg::TK_UNIT, 16'hDC00 + {6'd0, adj[9:0]});
          end else begin
            job = add_tok(job, ujse_pkg::TK_UNIT, part_ext[15:0]);
          end
          need_d = 2'd0;
          held_d = 2'd0;
          part_d = '0;
        end else begin
          hc_d[held_q[0]] = b;
          held_d          = held_q + 2'd1;
          part_d          = part_ext;
        end
      end else begin
        job    = add_flush(job, lead_q, held_q, hc_q[0], hc_q[1]);
        need_d = 2'd0;
        held_d = 2'd0;
        part_d = '0;
        fresh  = 1'b1;
      end

      if (fresh) begin
        job = add_fresh(job, b);
        if (b[7:5] == 3'b110) begin
          lead_d = b;
          need_d = 2'd1;
          held_d = 2'd0;
          part_d = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          lead_d = b;
          need_d = 2'd2;
          held_d = 2'd0;
          part_d = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          lead_d = b;
          need_d = 2'd3;
          held_d = 2'd0;
          part_d = {18'd0, b[2:0]};
        end
      end
    end

    if (in_i.end_of_string) begin
      if (need_d != 2'd0) begin
        job    = add_flush(job, lead_d, held_d, hc_d[0], hc_d[1]);
        need_d = 2'd0;
        held_d = 2'd0;
        part_d = '0;
      end
      job      = add_tok(job, ujse_pkg::TK_CLOSE, {9'd0, ujse_pkg::ChQuote});
      inside_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      lead_q   <= '0;
      need_q   <= '0;
      held_q   <= '0;
      part_q   <= '0;
    end else if (take) begin
      inside_q <= inside_d;
      lead_q   <= lead_d;
      need_q   <= need_d;
      held_q   <= held_d;
      part_q   <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hc_q <= hc_d;
    end
  end

endmodule

>>> src/ujse_queue.sv
// Job queue between the front end and the back end, with a look at the entry behind the head.
// Depends on ujse_pkg.
`timescale 1ns / 1ps

module ujse_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ujse_pkg::job_t    job_i,
  input  logic              pop_i,
  output ujse_pkg::job_t    head_o,
  output ujse_pkg::q_stat_t stat_o
);

  ujse_pkg::job_t mem_q [ujse_pkg::QDepth];
  logic           empty_q [ujse_pkg::QDepth];
  logic [ujse_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q, nxt_ptr;
  logic [ujse_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign nxt_ptr           = rd_ptr_q + 1'b1;
  assign head_o            = mem_q[rd_ptr_q];
  assign stat_o.head_valid = (cnt_q != '0);
  assign stat_o.next_valid = (cnt_q > ujse_pkg::QCntW'(1));
  assign stat_o.next_empty = empty_q[nxt_ptr];
  assign stat_o.full       = (cnt_q == ujse_pkg::QFull);

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= nxt_ptr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q]   <= job_i;
      empty_q[wr_ptr_q] <= (job_i.n_chr == '0);
    end
  end

endmodule

>>> src/ujse_back.sv
// Back end: head job to ASCII characters in an output register, one per cycle unless stalled.
// Depends on ujse_pkg and ujse_out_if.
`timescale 1ns / 1ps

module ujse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ujse_pkg::job_t    head_i,
  input  ujse_pkg::q_stat_t stat_i,
  output logic              pop_o,
  ujse_out_if.source        out_o
);

  logic [ujse_pkg::TokIdxW-1:0] tok_q, tok_d;
  logic [ujse_pkg::SubW-1:0]    sub_q, sub_d;
  logic [ujse_pkg::ChrW-1:0]    pos_q, pos_d;
  logic                         carry_q, carry_d;
  logic                         out_valid_q;
  logic [ujse_pkg::CharW-1:0]   out_byte_q;
  logic                         run_end_q;
  logic                         string_end_q;

  ujse_pkg::tok_t             cur;
  logic [ujse_pkg::SubW-1:0]  len;
  logic [ujse_pkg::CharW-1:0] ch;
  logic                       se;
  logic                       re;
  logic                       last_chr;
  logic                       at_limit;
  logic                       slot_free;
  logic                       skip;
  logic                       emit;

  assign cur       = head_i.tok[tok_q];
  assign len       = ujse_pkg::tok_len(cur.kind);
  assign last_chr  = (pos_q == head_i.n_chr - 1'b1);
  assign at_limit  = !carry_q && (pos_q == ujse_pkg::LimitPos);
  assign slot_free = !out_valid_q || out_o.ready;
  assign skip      = stat_i.head_valid && (head_i.n_chr == '0);
  assign emit      = stat_i.head_valid && (head_i.n_chr != '0) &&
                     (!carry_q || stat_i.next_valid) && slot_free;
  assign pop_o     = skip || (emit && last_chr);

  // Characters past the per-item limit belong to the next item's run, so they wait until
  // that item is queued; the run ends with the last of them only if that item is empty.
  assign re = carry_q ? (last_chr && stat_i.next_empty) : (last_chr || at_limit);

  always_comb begin
    ch = cur.val[6:0];
    se = 1'b0;
    case (cur.kind)
      ujse_pkg::TK_CHAR: begin
        ch = cur.val[6:0];
      end
      ujse_pkg::TK_CLOSE: begin
        ch = ujse_pkg::ChQuote;
        se = 1'b1;
      end
      ujse_pkg::TK_ESC: begin
        ch = (sub_q == '0) ? ujse_pkg::ChBslash : cur.val[6:0];
      end
      ujse_pkg::TK_UNIT: begin
        case (sub_q)
          3'd0:    ch = ujse_pkg::ChBslash;
          3'd1:    ch = ujse_pkg::ChLowU;
          3'd2:    ch = ujse_pkg::hex_char(cur.val[15:12]);
          3'd3:    ch = ujse_pkg::hex_char(cur.val[11:8]);
          3'd4:    ch = ujse_pkg::hex_char(cur.val[7:4]);
          default: ch = ujse_pkg::hex_char(cur.val[3:0]);
        endcase
      end
      default: begin
        ch = cur.val[6:0];
      end
    endcase
  end

  always_comb begin
    tok_d   = tok_q;
    sub_d   = sub_q;
    pos_d   = pos_q;
    carry_d = carry_q;
    if (emit) begin
      if (last_chr) begin
        tok_d   = '0;
        sub_d   = '0;
        pos_d   = '0;
        carry_d = 1'b0;
      end else begin
        pos_d = pos_q + 1'b1;
        if (at_limit) begin
          carry_d = 1'b1;
        end
        if (sub_q == len - 1'b1) begin
          sub_d = '0;
          tok_d = tok_q + 1'b1;
        end else begin
          sub_d = sub_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      sub_q       <= '0;
      pos_q       <= '0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      sub_q   <= sub_d;
      pos_q   <= pos_d;
      carry_q <= carry_d;
      if (slot_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q   <= ch;
      run_end_q    <= re;
      string_end_q <= se;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.run_end    = run_end_q;
  assign out_o.string_end = string_end_q;

endmodule
